// ----- rtl/core/qgs_pkg.sv -----
// Shared types, constants and gait tables for the quadruped gait sequencer.
package qgs_pkg;

  localparam int unsigned ANGLE_W = 8;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned LEGS    = 4;

  localparam logic [MODE_W-1:0]  GAIT_COUNT   = 4'd9;
  localparam logic [ANGLE_W-1:0] MIRROR       = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_CENTER = 8'd90;
  localparam logic [POS_W-1:0]   POS_FIRST    = 3'd1;
  localparam logic [ANGLE_W-1:0] ELAPSED_MAX  = 8'd255;

  localparam logic [MODE_W-1:0] MODE_RESET  = 4'd8;
  localparam logic [CFG_W-1:0]  SLEW_RESET  = 8'd5;

  // Leg order in the packed vectors: 0 front left, 1 front right,
  // 2 rear left, 3 rear right.
  localparam int unsigned LEG_FL = 0;
  localparam int unsigned LEG_FR = 1;
  localparam int unsigned LEG_RL = 2;
  localparam int unsigned LEG_RR = 3;

  // Configuration register indexes.
  localparam logic CFG_GAIT_MODE   = 1'b0;
  localparam logic CFG_SLEW_PERIOD = 1'b1;

  typedef logic [LEGS-1:0][ANGLE_W-1:0] angles_t;

  typedef struct packed {
    angles_t             cur;
    angles_t             tgt;
    logic [POS_W-1:0]    pos;
    logic [ANGLE_W-1:0]  elapsed;
  } gait_state_t;

  localparam angles_t CUR_RESET = {ANGLE_CENTER, ANGLE_CENTER, ANGLE_CENTER, ANGLE_CENTER};
  // rear right, rear left, front right, front left
  localparam angles_t TGT_RESET = {8'd0, 8'd180, 8'd180, 8'd0};

  function automatic logic [POS_W-1:0] gait_len(input logic [MODE_W-1:0] mode);
    logic [POS_W-1:0] len;
    case (mode)
      4'd0:    len = 3'd2;
      4'd1:    len = 3'd4;
      4'd2:    len = 3'd3;
      4'd3:    len = 3'd2;
      4'd4:    len = 3'd4;
      4'd5:    len = 3'd4;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd4;
      4'd8:    len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Raw table row {RR, RL, FR, FL} for a mode and a row index 0..3.
  function automatic angles_t gait_row(input logic [MODE_W-1:0] mode,
                                       input logic [1:0] row);
    angles_t r;
    r = '0;
    case ({mode, row})
      {4'd0, 2'd0}: r = {8'd120, 8'd0,   8'd0,   8'd120};
      {4'd0, 2'd1}: r = {8'd0,   8'd120, 8'd120, 8'd0};
      {4'd1, 2'd1}: r = {8'd0,   8'd0,   8'd80,  8'd80};
      {4'd1, 2'd2}: r = {8'd80,  8'd80,  8'd80,  8'd80};
      {4'd1, 2'd3}: r = {8'd80,  8'd80,  8'd0,   8'd0};
      {4'd2, 2'd0}: r = {8'd0,   8'd0,   8'd120, 8'd120};
      {4'd2, 2'd1}: r = {8'd120, 8'd120, 8'd0,   8'd0};
      {4'd3, 2'd1}: r = {8'd80,  8'd80,  8'd80,  8'd80};
      {4'd4, 2'd0}: r = {8'd120, 8'd0,   8'd0,   8'd120};
      {4'd4, 2'd1}: r = {8'd0,   8'd120, 8'd120, 8'd0};
      {4'd4, 2'd2}: r = {8'd120, 8'd120, 8'd0,   8'd0};
      {4'd4, 2'd3}: r = {8'd0,   8'd0,   8'd120, 8'd120};
      {4'd5, 2'd0}: r = {8'd0,   8'd0,   8'd120, 8'd120};
      {4'd5, 2'd1}: r = {8'd120, 8'd120, 8'd0,   8'd0};
      {4'd5, 2'd2}: r = {8'd0,   8'd120, 8'd0,   8'd120};
      {4'd5, 2'd3}: r = {8'd0,   8'd0,   8'd120, 8'd0};
      {4'd6, 2'd0}: r = {8'd0,   8'd120, 8'd0,   8'd120};
      {4'd6, 2'd1}: r = {8'd120, 8'd0,   8'd120, 8'd0};
      {4'd7, 2'd0}: r = {8'd0,   8'd0,   8'd120, 8'd0};
      {4'd7, 2'd1}: r = {8'd120, 8'd0,   8'd120, 8'd0};
      {4'd7, 2'd2}: r = {8'd120, 8'd0,   8'd0,   8'd0};
      {4'd8, 2'd0}: r = {8'd0,   8'd0,   8'd0,   8'd120};
      {4'd8, 2'd1}: r = {8'd0,   8'd120, 8'd0,   8'd120};
      {4'd8, 2'd2}: r = {8'd0,   8'd120, 8'd0,   8'd0};
      default:      r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/qgs_in_if.sv -----
// Input channel: one loop pass with an optional millisecond tick.
interface qgs_in_if;
  logic valid;
  logic ready;
  logic ms_tick;

  modport source (output valid, output ms_tick, input ready);
  modport sink   (input valid, input ms_tick, output ready);
endinterface

// ----- rtl/core/qgs_out_if.sv -----
// Result channel: four servo angles and the next gait step.
interface qgs_out_if;
  logic                          valid;
  logic                          ready;
  logic [qgs_pkg::ANGLE_W-1:0]   angle_fl;
  logic [qgs_pkg::ANGLE_W-1:0]   angle_fr;
  logic [qgs_pkg::ANGLE_W-1:0]   angle_rl;
  logic [qgs_pkg::ANGLE_W-1:0]   angle_rr;
  logic [qgs_pkg::POS_W-1:0]     step_number;

  modport source (output valid, output angle_fl, output angle_fr,
                  output angle_rl, output angle_rr,
                  output step_number, input ready);
  modport sink   (input valid, input angle_fl, input angle_fr,
                  input angle_rl, input angle_rr,
                  input step_number, output ready);
endinterface

// ----- rtl/core/qgs_step.sv -----
// Next-state logic for one loop pass: gait table lookup, slew timer, servo moves.
module qgs_step (
  input  qgs_pkg::gait_state_t                 st,
  input  logic                                 ms_tick,
  input  logic [qgs_pkg::MODE_W-1:0]           gait_mode,
  input  logic [qgs_pkg::CFG_W-1:0]            slew_period,
  output qgs_pkg::gait_state_t                 st_nxt
);

  logic                              at_target;
  logic                              apply;
  logic [qgs_pkg::POS_W-1:0]         len;
  logic [1:0]                        row_idx;
  qgs_pkg::angles_t                  row;
  qgs_pkg::angles_t                  tgt_mid;
  logic [qgs_pkg::POS_W-1:0]         pos_mid;
  logic [qgs_pkg::ANGLE_W-1:0]       elapsed_inc;
  logic                              move;

  assign at_target = (st.cur == st.tgt);
  assign len       = qgs_pkg::gait_len(gait_mode);
  assign apply     = at_target && (gait_mode < qgs_pkg::GAIT_COUNT) &&
                     (st.pos != '0) && (st.pos <= len);
  assign row_idx   = 2'(st.pos - qgs_pkg::POS_FIRST);
  assign row       = qgs_pkg::gait_row(gait_mode, row_idx);

  always_comb begin
    tgt_mid = st.tgt;
    pos_mid = st.pos;
    if (apply) begin
      tgt_mid[qgs_pkg::LEG_FL] = row[qgs_pkg::LEG_FL];
      tgt_mid[qgs_pkg::LEG_FR] = qgs_pkg::MIRROR - row[qgs_pkg::LEG_FR];
      tgt_mid[qgs_pkg::LEG_RL] = qgs_pkg::MIRROR - row[qgs_pkg::LEG_RL];
      tgt_mid[qgs_pkg::LEG_RR] = row[qgs_pkg::LEG_RR];
      pos_mid = (st.pos == len) ? qgs_pkg::POS_FIRST : st.pos + qgs_pkg::POS_FIRST;
    end
  end

  // tick counter saturates at its max
  assign elapsed_inc = (ms_tick && (st.elapsed != qgs_pkg::ELAPSED_MAX)) ?
                       st.elapsed + 8'd1 : st.elapsed;
  assign move = (elapsed_inc >= slew_period);

  always_comb begin
    st_nxt.tgt     = tgt_mid;
    st_nxt.pos     = pos_mid;
    st_nxt.elapsed = move ? '0 : elapsed_inc;
    for (int i = 0; i < qgs_pkg::LEGS; i++) begin
      st_nxt.cur[i] = st.cur[i];
      if (move) begin
        if (tgt_mid[i] > st.cur[i])
          st_nxt.cur[i] = st.cur[i] + 8'd1;
        else if (tgt_mid[i] < st.cur[i])
          st_nxt.cur[i] = st.cur[i] - 8'd1;
      end
    end
  end

endmodule

// ----- rtl/core/quadruped_gait_sequencer.sv -----
// Quadruped gait sequencer: takes one loop pass per cycle and returns the four
// leg servo angles and the next gait step after that pass. Each transaction on
// in_ch is captured in an input register, then the gait table lookup, slew
// timer and one-degree servo moves are evaluated combinationally and the
// result lands in the output register; the sustained rate is one transaction
// per cycle whenever out_ch is ready.
// The gait state register is the only loop; it updates once per item.
// Configuration (gait_mode, slew_period) must be written while no transaction
// is in flight.
module quadruped_gait_sequencer (
  input  logic                         clk,
  input  logic                         rst_n,
  qgs_in_if.sink                       in_ch,
  qgs_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [qgs_pkg::CFG_W-1:0]    cfg_data
);

  logic                            in_valid_r;
  logic                            in_tick_r;
  logic                            res_valid_r;
  logic                            advance;
  logic                            process;
  logic [qgs_pkg::MODE_W-1:0]      gait_mode_r;
  logic [qgs_pkg::CFG_W-1:0]       slew_period_r;
  qgs_pkg::gait_state_t            st_r;
  qgs_pkg::gait_state_t            st_nxt;
  qgs_pkg::angles_t                res_angles_r;
  logic [qgs_pkg::POS_W-1:0]       res_pos_r;

  assign advance     = !res_valid_r || out_ch.ready;
  assign process     = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_tick_r <= in_ch.ms_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gait_mode_r   <= qgs_pkg::MODE_RESET;
      slew_period_r <= qgs_pkg::SLEW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qgs_pkg::CFG_GAIT_MODE:   gait_mode_r   <= cfg_data[qgs_pkg::MODE_W-1:0];
        qgs_pkg::CFG_SLEW_PERIOD: slew_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  qgs_step u_step (
    .st          (st_r),
    .ms_tick     (in_tick_r),
    .gait_mode   (gait_mode_r),
    .slew_period (slew_period_r),
    .st_nxt      (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.cur     <= qgs_pkg::CUR_RESET;
      st_r.tgt     <= qgs_pkg::TGT_RESET;
      st_r.pos     <= qgs_pkg::POS_FIRST;
      st_r.elapsed <= '0;
    end else if (process) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      res_angles_r <= st_nxt.cur;
      res_pos_r    <= st_nxt.pos;
    end
  end

  assign out_ch.valid       = res_valid_r;
  assign out_ch.angle_fl    = res_angles_r[qgs_pkg::LEG_FL];
  assign out_ch.angle_fr    = res_angles_r[qgs_pkg::LEG_FR];
  assign out_ch.angle_rl    = res_angles_r[qgs_pkg::LEG_RL];
  assign out_ch.angle_rr    = res_angles_r[qgs_pkg::LEG_RR];
  assign out_ch.step_number = res_pos_r;

  // gait step never leaves 1..4
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.pos != '0) && (st_r.pos <= 3'd4))
    else $error("gait step out of range");

  // servo angles stay within 0..180
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.cur[0] <= qgs_pkg::MIRROR) && (st_r.cur[1] <= qgs_pkg::MIRROR) &&
    (st_r.cur[2] <= qgs_pkg::MIRROR) && (st_r.cur[3] <= qgs_pkg::MIRROR))
    else $error("servo angle above 180");

  // a processed item always produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    process |=> res_valid_r)
    else $error("processed transaction produced no result");

  // state only changes when an item is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !process |=> $stable(st_r))
    else $error("gait state changed without a transaction");

endmodule

// ----- tb/tb_quadruped_gait_sequencer.sv -----
// Self-checking testbench for the quadruped gait sequencer: directed script, then random phases.
module tb_quadruped_gait_sequencer;

  typedef enum logic [3:0] {
    GAIT_CRAWL, GAIT_UNDULATE, GAIT_PUSHER, GAIT_SIMULTANEOUS, GAIT_RIPPLE,
    GAIT_ALTERNATE, GAIT_DIAGONAL, GAIT_TURN_LEFT, GAIT_TURN_RIGHT
  } gait_e;

  localparam logic [3:0] GAIT_UNUSED_LO = 4'd9;
  localparam logic [3:0] GAIT_UNUSED_HI = 4'd15;

  localparam logic IDX_MODE = qgs_pkg::CFG_GAIT_MODE;
  localparam logic IDX_SLEW = qgs_pkg::CFG_SLEW_PERIOD;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_COMB, SINK_SPARSE} sink_style_e;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [qgs_pkg::ANGLE_W-1:0] fl;
    logic [qgs_pkg::ANGLE_W-1:0] fr;
    logic [qgs_pkg::ANGLE_W-1:0] rl;
    logic [qgs_pkg::ANGLE_W-1:0] rr;
    logic [qgs_pkg::POS_W-1:0]   step_no;
  } pose_t;

  typedef struct packed {
    logic  on;
    pose_t pose;
  } pinned_pose_t;

  typedef struct packed {
    row_kind_e                 kind;
    logic                      tick;
    logic                      cfg_idx;
    logic [qgs_pkg::CFG_W-1:0] cfg_val;
    logic                      pinned;
    pose_t                     pose;
  } script_row_t;

  localparam pose_t NO_POSE = '0;

  // Stride rows per gait, legs in FL, FR, RL, RR order, before mirroring.
  localparam logic [0:8][0:3][0:3][7:0] STRIDE_TABLE = {
    8'd120, 8'd0,   8'd0,   8'd120, 8'd0,   8'd120, 8'd120, 8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd80,  8'd80,  8'd0,   8'd0,
    8'd80,  8'd80,  8'd80,  8'd80,  8'd0,   8'd0,   8'd80,  8'd80,
    8'd120, 8'd120, 8'd0,   8'd0,   8'd0,   8'd0,   8'd120, 8'd120,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd80,  8'd80,  8'd80,  8'd80,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd120, 8'd0,   8'd0,   8'd120, 8'd0,   8'd120, 8'd120, 8'd0,
    8'd0,   8'd0,   8'd120, 8'd120, 8'd120, 8'd120, 8'd0,   8'd0,
    8'd120, 8'd120, 8'd0,   8'd0,   8'd0,   8'd0,   8'd120, 8'd120,
    8'd120, 8'd0,   8'd120, 8'd0,   8'd0,   8'd120, 8'd0,   8'd0,
    8'd120, 8'd0,   8'd120, 8'd0,   8'd0,   8'd120, 8'd0,   8'd120,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd120, 8'd0,   8'd0,   8'd0,   8'd120, 8'd0,   8'd120,
    8'd0,   8'd0,   8'd0,   8'd120, 8'd0,   8'd0,   8'd0,   8'd0,
    8'd120, 8'd0,   8'd0,   8'd0,   8'd120, 8'd0,   8'd120, 8'd0,
    8'd0,   8'd0,   8'd120, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };
  localparam logic [0:8][2:0] STRIDE_LEN =
    {3'd2, 3'd4, 3'd3, 3'd2, 3'd4, 3'd4, 3'd2, 3'd4, 3'd4};

  localparam int SCRIPT_ROWS = 24;
  localparam script_row_t SCRIPT [0:SCRIPT_ROWS-1] = '{
    '{ROW_ITEM, 1'b0, IDX_MODE, 8'd0, 1'b1, '{8'd90, 8'd90, 8'd90, 8'd90, 3'd1}},
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b1, '{8'd90, 8'd90, 8'd90, 8'd90, 3'd1}},
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b1, '{8'd90, 8'd90, 8'd90, 8'd90, 3'd1}},
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b1, '{8'd90, 8'd90, 8'd90, 8'd90, 3'd1}},
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b1, '{8'd90, 8'd90, 8'd90, 8'd90, 3'd1}},
    // fifth tick reaches the reset period: first one-degree move
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b1, '{8'd89, 8'd91, 8'd91, 8'd89, 3'd1}},
    '{ROW_ITEM, 1'b0, IDX_MODE, 8'd0, 1'b1, '{8'd89, 8'd91, 8'd91, 8'd89, 3'd1}},
    // zero period: a move on every pass, tick or not
    '{ROW_CFG,  1'b0, IDX_SLEW, 8'd0, 1'b0, NO_POSE},
    '{ROW_ITEM, 1'b0, IDX_MODE, 8'd0, 1'b0, NO_POSE},
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b0, NO_POSE},
    // all ones: upper nibble dropped, lands on an unused mode
    '{ROW_CFG,  1'b0, IDX_MODE, 8'hFF, 1'b0, NO_POSE},
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b0, NO_POSE},
    '{ROW_ITEM, 1'b0, IDX_MODE, 8'd0, 1'b0, NO_POSE},
    '{ROW_CFG,  1'b0, IDX_SLEW, 8'd255, 1'b0, NO_POSE},
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b0, NO_POSE},
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b0, NO_POSE},
    '{ROW_CFG,  1'b0, IDX_MODE, 8'(GAIT_CRAWL), 1'b0, NO_POSE},
    '{ROW_CFG,  1'b0, IDX_SLEW, 8'd1, 1'b0, NO_POSE},
    '{ROW_ITEM, 1'b0, IDX_MODE, 8'd0, 1'b0, NO_POSE},
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b0, NO_POSE},
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b0, NO_POSE},
    '{ROW_CFG,  1'b0, IDX_MODE, 8'(GAIT_TURN_RIGHT), 1'b0, NO_POSE},
    '{ROW_CFG,  1'b0, IDX_SLEW, 8'd5, 1'b0, NO_POSE},
    '{ROW_ITEM, 1'b1, IDX_MODE, 8'd0, 1'b0, NO_POSE}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [qgs_pkg::CFG_W-1:0] cfg_data;

  qgs_in_if  in_ch ();
  qgs_out_if out_ch ();

  quadruped_gait_sequencer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sequencer state as predicted.
  qgs_pkg::angles_t                servo_now;
  qgs_pkg::angles_t                servo_goal;
  logic [qgs_pkg::POS_W-1:0]       stride_pos;
  logic [qgs_pkg::ANGLE_W-1:0]     tick_count;
  logic [qgs_pkg::MODE_W-1:0]      pred_mode;
  logic [qgs_pkg::CFG_W-1:0]       pred_slew;

  pose_t        pending_poses [$];
  pinned_pose_t typed_poses [$];

  int fail_count     = 0;
  int items_taken    = 0;
  int results_seen   = 0;
  int regs_written   = 0;
  int strides_taken  = 0;
  int stride_out     = 0;
  int unused_holds   = 0;
  int zero_slew_runs = 0;
  int burst_left;
  int hold_left      = 0;
  int window         = 0;
  bit long_hold_done = 1'b0;
  sink_style_e sink_style = SINK_OPEN;

  pose_t predicted;
  pose_t got;
  pose_t want;
  pinned_pose_t pin;
  string diff;

  task automatic note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic step_servos(input logic tick, output pose_t pose);
    logic at_goal;
    logic [2:0] len;
    logic [0:3][7:0] raw;
    at_goal = 1'b1;
    for (int leg = 0; leg < qgs_pkg::LEGS; leg++)
      if (servo_now[leg] != servo_goal[leg]) at_goal = 1'b0;
    if (at_goal) begin
      if (pred_mode >= qgs_pkg::GAIT_COUNT) begin
        unused_holds++;
      end else begin
        len = STRIDE_LEN[pred_mode];
        if (stride_pos < 1 || stride_pos > len) begin
          stride_out++;
        end else begin
          raw = STRIDE_TABLE[pred_mode][stride_pos - 1];
          servo_goal[qgs_pkg::LEG_FL] = raw[0];
          servo_goal[qgs_pkg::LEG_FR] = qgs_pkg::MIRROR - raw[1];
          servo_goal[qgs_pkg::LEG_RL] = qgs_pkg::MIRROR - raw[2];
          servo_goal[qgs_pkg::LEG_RR] = raw[3];
          stride_pos = (stride_pos == len) ? qgs_pkg::POS_FIRST : stride_pos + 3'd1;
          strides_taken++;
        end
      end
    end
    if (tick && tick_count != qgs_pkg::ELAPSED_MAX) tick_count++;
    if (pred_slew == 0) zero_slew_runs++;
    if (tick_count >= pred_slew) begin
      tick_count = '0;
      for (int leg = 0; leg < qgs_pkg::LEGS; leg++) begin
        if (servo_goal[leg] > servo_now[leg]) servo_now[leg]++;
        else if (servo_goal[leg] < servo_now[leg]) servo_now[leg]--;
      end
    end
    pose = '{servo_now[qgs_pkg::LEG_FL], servo_now[qgs_pkg::LEG_FR],
             servo_now[qgs_pkg::LEG_RL], servo_now[qgs_pkg::LEG_RR], stride_pos};
  endtask

  // Register writes wait for the pipe to drain.
  task automatic write_reg(input logic idx, input logic [qgs_pkg::CFG_W-1:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_poses.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == IDX_MODE) pred_mode = val[qgs_pkg::MODE_W-1:0];
    else pred_slew = val;
    regs_written++;
  endtask

  task automatic offer(input logic tick, input logic on, input pose_t pose);
    typed_poses.push_back('{on, pose});
    if (!in_ch.valid) in_ch.valid <= 1'b1;
    in_ch.ms_tick <= tick;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      step_servos(in_ch.ms_tick, predicted);
      pin = typed_poses.pop_front();
      pending_poses.push_back(pin.on ? pin.pose : predicted);
      items_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.angle_fl, out_ch.angle_fr, out_ch.angle_rl,
              out_ch.angle_rr, out_ch.step_number};
      if (pending_poses.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: %0d/%0d/%0d/%0d step %0d",
                                got.fl, got.fr, got.rl, got.rr, got.step_no));
      end else begin
        want = pending_poses.pop_front();
        diff = "";
        if (got.fl !== want.fl) diff = {diff, " fl"};
        if (got.fr !== want.fr) diff = {diff, " fr"};
        if (got.rl !== want.rl) diff = {diff, " rl"};
        if (got.rr !== want.rr) diff = {diff, " rr"};
        if (got.step_no !== want.step_no) diff = {diff, " step_number"};
        if (diff != "")
          note_mismatch($sformatf(
            "result %0d:%s expected %0d/%0d/%0d/%0d step %0d, got %0d/%0d/%0d/%0d step %0d",
            results_seen, diff, want.fl, want.fr, want.rl, want.rr, want.step_no,
            got.fl, got.fr, got.rl, got.rr, got.step_no));
      end
      results_seen++;
    end
  end

  // Receiver: changing stall styles plus one long hold-off once traffic is flowing.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && !long_hold_done && results_seen >= 700) begin
        hold_left      = 400;
        long_hold_done = 1'b1;
      end
      if (window == 0) begin
        sink_style = sink_style_e'($urandom_range(0, 3));
        window     = $urandom_range(20, 80);
      end
      window--;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (sink_style)
          SINK_OPEN: out_ch.ready <= 1'b1;
          SINK_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
          SINK_COMB: out_ch.ready <= (window % 4 != 0);
          default:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int pick;
    int tick_pct;
    int phase_len;
    int random_sent;
    int drain_wait;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.ms_tick <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= IDX_MODE;
    cfg_data      <= '0;
    servo_now  = qgs_pkg::CUR_RESET;
    servo_goal = qgs_pkg::TGT_RESET;
    stride_pos = qgs_pkg::POS_FIRST;
    tick_count = '0;
    pred_mode  = qgs_pkg::MODE_RESET;
    pred_slew  = qgs_pkg::SLEW_RESET;
    burst_left = $urandom_range(1, 30);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (SCRIPT[r].kind == ROW_CFG) write_reg(SCRIPT[r].cfg_idx, SCRIPT[r].cfg_val);
      else offer(SCRIPT[r].tick, SCRIPT[r].pinned, SCRIPT[r].pose);
    end

    // Random phases: mostly real gaits with short slew so legs reach their targets.
    random_sent = 0;
    while (random_sent < 2000) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        write_reg(IDX_MODE, {4'($urandom_range(0, 15)),
                             4'($urandom_range(GAIT_CRAWL, GAIT_TURN_RIGHT))});
      else if (pick == 7)
        write_reg(IDX_MODE, {4'($urandom_range(0, 15)),
                             4'($urandom_range(GAIT_UNUSED_LO, GAIT_UNUSED_HI))});
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: write_reg(IDX_SLEW, 8'd0);
        3, 4, 5: write_reg(IDX_SLEW, 8'd1);
        6, 7:    write_reg(IDX_SLEW, 8'($urandom_range(2, 4)));
        8:       write_reg(IDX_SLEW, 8'd255);
        default: write_reg(IDX_SLEW, 8'($urandom_range(0, 255)));
      endcase
      pick     = $urandom_range(0, 2);
      tick_pct = (pick == 0) ? 100 : (pick == 1) ? 60 : 15;
      phase_len = $urandom_range(20, 250);
      repeat (phase_len) begin
        offer($urandom_range(0, 99) < tick_pct, 1'b0, NO_POSE);
        random_sent++;
      end
    end

    in_ch.valid <= 1'b0;
    drain_wait = 0;
    while (pending_poses.size() != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (8) @(posedge clk);
    if (pending_poses.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_poses.size()));
      fail_count += pending_poses.size() - 1;
    end

    $display("covered %0d loop passes, %0d results, %0d register writes",
             items_taken, results_seen, regs_written);
    $display("gait steps %0d, past-length holds %0d, unused-mode holds %0d, zero-period passes %0d",
             strides_taken, stride_out, unused_holds, zero_slew_runs);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
